>>> rtl/imf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_pkg
// Shared types and constants of the image median filter.
// ----------------------------------------------------------------------------
package imf_pkg;

    localparam int PIX_W     = 16;
    localparam int POS_W     = 10;
    localparam int SIZE_W    = 11;
    localparam int HALF_W    = 2;
    localparam int SLOT_W    = 3;
    localparam int CNT_W     = 6;
    localparam int BIT_IDX_W = 4;
    localparam int LINE_ROWS = 7;
    localparam int MAX_COLS  = 1024;
    localparam int MEM_DEPTH = LINE_ROWS * MAX_COLS;
    localparam int ADDR_W    = SLOT_W + POS_W;

    localparam logic [SIZE_W-1:0]  MAX_ROWS_V = 11'd1024;
    localparam logic [SIZE_W-1:0]  MAX_COLS_V = 11'd1024;
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = 3'd6;
    localparam logic [PIX_W-1:0]   SIGN_FLIP  = 16'h8000;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_HALF = 2'd2;

    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ISSUE,
        S_TAIL,
        S_DECIDE,
        S_OUT,
        S_ADV
    } t_state;

    typedef struct packed {
        logic start;
        logic sample;
        logic decide;
    } t_sel_ctl;

endpackage

>>> rtl/imf_rank_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_rank_sel
// Bit-serial rank selection: one counting pass over the window per bit.
// ----------------------------------------------------------------------------
module imf_rank_sel
    import imf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_sel_ctl             i_ctl,
    input  logic [CNT_W-1:0]     i_k,
    input  logic [PIX_W-1:0]     i_sample,
    output logic                 o_last,
    output logic [PIX_W-1:0]     o_median
);

    logic [PIX_W-1:0]     r_prefix, n_prefix;
    logic [PIX_W-1:0]     r_mask, n_mask;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [PIX_W-1:0]     key;
    logic [PIX_W-1:0]     one_bit;
    logic                 hit;

    always_comb begin
        key     = i_sample ^ SIGN_FLIP;
        one_bit = PIX_W'(1) << r_bit;
        hit     = (((key ^ r_prefix) & r_mask) == '0) && !key[r_bit];
        n_prefix = r_prefix;
        n_mask   = r_mask;
        n_bit    = r_bit;
        n_k      = r_k;
        n_cnt    = r_cnt;
        if (i_ctl.start) begin
            n_prefix = '0;
            n_mask   = '0;
            n_bit    = BIT_IDX_W'(PIX_W - 1);
            n_k      = i_k;
            n_cnt    = '0;
        end else if (i_ctl.decide) begin
            if (r_k >= r_cnt) begin
                n_prefix = r_prefix | one_bit;
                n_k      = r_k - r_cnt;
            end
            n_mask = r_mask | one_bit;
            n_bit  = r_bit - 1'b1;
            n_cnt  = '0;
        end else if (i_ctl.sample && hit) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
            r_cnt <= '0;
        end else begin
            r_bit <= n_bit;
            r_cnt <= n_cnt;
        end
        r_prefix <= n_prefix;
        r_mask   <= n_mask;
        r_k      <= n_k;
    end

    assign o_last   = (r_bit == '0);
    assign o_median = r_prefix ^ SIGN_FLIP;

endmodule

>>> rtl/image_median_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_median_filter
// Streaming 2-D median filter with clipped windows and line storage.
// ----------------------------------------------------------------------------
// Each output pixel takes 16 counting passes over its window, one per bit,
// where the window is clipped at the image edges (up to 49 pixels).
// A new input item is not accepted until every output it causes is taken.
// Window pixels are read one at a time through the line store port feeding the shared rank unit.
// Synchronous active-low reset clears control state; the line store is not
// cleared and is only read where the current frame wrote it.
module image_median_filter
    import imf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [15:0]        i_s_tdata,   // pixel_in
    input  logic               i_s_tuser,   // opcode
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [39:0]        o_m_tdata,   // median_out, out_row, out_col, zero pad
    output logic               o_m_tlast,   // run_last
    output logic               o_m_tuser,   // frame_done
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data
);

    t_state r_state, n_state;

    logic [SIZE_W-1:0] r_rows_cfg, n_rows_cfg;
    logic [SIZE_W-1:0] r_cols_cfg, n_cols_cfg;
    logic [HALF_W-1:0] r_half, n_half;
    logic [SIZE_W-1:0] r_in_row, n_in_row;
    logic [POS_W-1:0]  r_in_col, n_in_col;
    logic [SLOT_W-1:0] r_wslot, n_wslot;
    logic [SIZE_W-1:0] r_orow, n_orow;
    logic [POS_W-1:0]  r_oc, n_oc;
    logic [POS_W-1:0]  r_hi, n_hi;
    logic              r_done, n_done;
    logic [POS_W-1:0]  r_c0, n_c0;
    logic [SLOT_W-1:0] r_nr, n_nr;
    logic [SLOT_W-1:0] r_nc, n_nc;
    logic [SLOT_W-1:0] r_sslot, n_sslot;
    logic [SLOT_W-1:0] r_ri, n_ri;
    logic [SLOT_W-1:0] r_ci, n_ci;
    logic [SLOT_W-1:0] r_rslot, n_rslot;
    logic [POS_W-1:0]  r_ccol, n_ccol;
    logic              r_rd_v;
    logic [PIX_W-1:0]  r_rdata;
    logic [PIX_W-1:0]  mem [0:MEM_DEPTH-1];

    logic [SIZE_W-1:0] rows_e, cols_e, h11, col11, rmax, cmax;
    logic [SIZE_W-1:0] r0, r1, c0, c1, oc11, rdist;
    logic [SIZE_W-1:0] lo, hi, colp, rowp;
    logic [POS_W-1:0]  col_f;
    logic              drain_ph, has_out, any_out, fd;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CNT_W-1:0]  win_n;
    logic [SLOT_W-1:0] dslot;
    t_sel_ctl          sel_ctl;
    logic              sel_last;
    logic [PIX_W-1:0]  sel_med;

    imf_rank_sel u_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (sel_ctl),
        .i_k      (win_n >> 1),
        .i_sample (r_rdata),
        .o_last   (sel_last),
        .o_median (sel_med)
    );

    always_comb begin
        rows_e = (r_rows_cfg == '0) ? SIZE_W'(1) :
                 (r_rows_cfg > MAX_ROWS_V) ? MAX_ROWS_V : r_rows_cfg;
        cols_e = (r_cols_cfg == '0) ? SIZE_W'(1) :
                 (r_cols_cfg > MAX_COLS_V) ? MAX_COLS_V : r_cols_cfg;
        h11    = SIZE_W'(r_half);
        rmax   = rows_e - 1'b1;
        cmax   = cols_e - 1'b1;

        drain_ph = (r_in_row >= rows_e);
        col_f    = ({1'b0, r_in_col} >= cols_e) ? '0 : r_in_col;
        col11    = {1'b0, col_f};
        has_out  = (r_in_row >= h11) && ((r_in_row - h11) < rows_e);
        lo       = '0;
        hi       = '0;
        any_out  = 1'b0;
        if (col11 + 1'b1 == cols_e) begin
            lo      = (col11 > h11) ? col11 - h11 : '0;
            hi      = cmax;
            any_out = 1'b1;
        end else if (col11 >= h11) begin
            lo      = col11 - h11;
            hi      = lo;
            any_out = 1'b1;
        end

        oc11  = {1'b0, r_oc};
        r0    = (r_orow > h11) ? r_orow - h11 : '0;
        r1    = (r_orow + h11 < rows_e) ? r_orow + h11 : rmax;
        c0    = (oc11 > h11) ? oc11 - h11 : '0;
        c1    = (oc11 + h11 < cols_e) ? oc11 + h11 : cmax;
        rdist = r_in_row - r0;
        dslot = rdist[SLOT_W-1:0];
        win_n = CNT_W'(SLOT_W'(r1 - r0 + 1'b1)) * CNT_W'(SLOT_W'(c1 - c0 + 1'b1));
        fd    = (r_orow + 1'b1 == rows_e) && (oc11 + 1'b1 == cols_e);

        colp = {1'b0, r_in_col} + 1'b1;
        rowp = r_in_row + 1'b1;
    end

    always_comb begin
        n_state    = r_state;
        n_rows_cfg = r_rows_cfg;
        n_cols_cfg = r_cols_cfg;
        n_half     = r_half;
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_wslot    = r_wslot;
        n_orow     = r_orow;
        n_oc       = r_oc;
        n_hi       = r_hi;
        n_done     = r_done;
        n_c0       = r_c0;
        n_nr       = r_nr;
        n_nc       = r_nc;
        n_sslot    = r_sslot;
        n_ri       = r_ri;
        n_ci       = r_ci;
        n_rslot    = r_rslot;
        n_ccol     = r_ccol;
        sel_ctl    = '0;
        we         = 1'b0;
        o_s_tready = 1'b0;
        o_cfg_ready = 1'b0;
        o_m_tvalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_s_tready  = !i_cfg_valid;
                if (i_cfg_valid) begin
                    if (i_cfg_index != 2'd3) begin
                        n_in_row = '0;
                        n_in_col = '0;
                        n_wslot  = '0;
                    end
                    unique case (i_cfg_index)
                        REG_ROWS: n_rows_cfg = i_cfg_data;
                        REG_COLS: n_cols_cfg = i_cfg_data;
                        REG_HALF: n_half     = i_cfg_data[HALF_W-1:0];
                        default: ;
                    endcase
                end else if (i_s_tvalid && !(i_s_tuser == OP_DRAIN && !drain_ph)) begin
                    we       = !drain_ph;
                    n_in_col = col_f;
                    n_done   = 1'b0;
                    if (has_out && any_out) begin
                        n_orow  = r_in_row - h11;
                        n_oc    = lo[POS_W-1:0];
                        n_hi    = hi[POS_W-1:0];
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_ADV;
                    end
                end
            end
            S_SETUP: begin
                sel_ctl.start = 1'b1;
                n_c0    = c0[POS_W-1:0];
                n_nr    = SLOT_W'(r1 - r0);
                n_nc    = SLOT_W'(c1 - c0);
                n_sslot = (r_wslot >= dslot) ? r_wslot - dslot
                                             : SLOT_W'(r_wslot + 3'd7 - dslot);
                n_rslot = n_sslot;
                n_ri    = '0;
                n_ci    = '0;
                n_ccol  = c0[POS_W-1:0];
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                sel_ctl.sample = r_rd_v;
                if (r_ci == r_nc) begin
                    n_ci   = '0;
                    n_ccol = r_c0;
                    n_ri   = r_ri + 1'b1;
                    n_rslot = (r_rslot == LAST_SLOT) ? '0 : r_rslot + 1'b1;
                    if (r_ri == r_nr) begin
                        n_state = S_TAIL;
                    end
                end else begin
                    n_ci   = r_ci + 1'b1;
                    n_ccol = r_ccol + 1'b1;
                end
            end
            S_TAIL: begin
                sel_ctl.sample = r_rd_v;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                sel_ctl.decide = 1'b1;
                n_ri    = '0;
                n_ci    = '0;
                n_rslot = r_sslot;
                n_ccol  = r_c0;
                n_state = sel_last ? S_OUT : S_ISSUE;
            end
            S_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_done = r_done | fd;
                    if (r_oc == r_hi) begin
                        n_state = S_ADV;
                    end else begin
                        n_oc    = r_oc + 1'b1;
                        n_state = S_SETUP;
                    end
                end
            end
            S_ADV: begin
                n_state = S_IDLE;
                if (r_done) begin
                    n_in_row = '0;
                    n_in_col = '0;
                    n_wslot  = '0;
                end else if (colp >= cols_e) begin
                    n_in_col = '0;
                    if (rowp >= rows_e + h11) begin
                        n_in_row = '0;
                        n_wslot  = '0;
                    end else begin
                        n_in_row = rowp;
                        n_wslot  = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
                    end
                end else begin
                    n_in_col = colp[POS_W-1:0];
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign waddr = {r_wslot, col_f};
    assign raddr = {r_rslot, r_ccol};

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= i_s_tdata;
        end
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rows_cfg <= MAX_ROWS_V;
            r_cols_cfg <= MAX_COLS_V;
            r_half     <= 2'd1;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_wslot    <= '0;
            r_done     <= 1'b0;
            r_rd_v     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rows_cfg <= n_rows_cfg;
            r_cols_cfg <= n_cols_cfg;
            r_half     <= n_half;
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_wslot    <= n_wslot;
            r_done     <= n_done;
            r_rd_v     <= (r_state == S_ISSUE);
        end
        r_orow  <= n_orow;
        r_oc    <= n_oc;
        r_hi    <= n_hi;
        r_c0    <= n_c0;
        r_nr    <= n_nr;
        r_nc    <= n_nc;
        r_sslot <= n_sslot;
        r_ri    <= n_ri;
        r_ci    <= n_ci;
        r_rslot <= n_rslot;
        r_ccol  <= n_ccol;
    end

    assign o_m_tdata = {4'b0, r_oc, r_orow[POS_W-1:0], sel_med};
    assign o_m_tlast = (r_oc == r_hi);
    assign o_m_tuser = fd;

endmodule

>>> rtl/imf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imf_checker
// Port-level checks of the image median filter, bound to the top level.
// ----------------------------------------------------------------------------
module imf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic o_s_tready,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic o_m_tlast,
    input logic o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("Result dropped before it was taken.");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("Input ready while a result is pending.");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("Frame end is not the last result of its request.");

    a_setup_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_m_tvalid)
        else $error("Result offered right after a request.");

endmodule

bind image_median_filter imf_checker u_imf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
